### hw/rtl/acs_pkg.sv
// shared types and constants for the accumulator machine step block
// no dependencies; imported by acs_mem, acs_alu and accumulator_cpu_step
package acs_pkg;

  localparam int unsigned MemDepth = 32;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam int unsigned DataW    = 8;
  localparam int unsigned OpW      = 3;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_EXEC  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [OpW-1:0] {
    OP_LOAD  = 3'd0,
    OP_STORE = 3'd1,
    OP_ADD   = 3'd2,
    OP_SUB   = 3'd3,
    OP_AND   = 3'd4,
    OP_OR    = 3'd5,
    OP_NOT   = 3'd6,
    OP_JUMP  = 3'd7
  } op_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

### hw/rtl/acs_mem.sv
// shared program and data memory, one write and one registered read port
// per-word valid bits give the all-zero contents after reset; uses acs_pkg
module acs_mem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  acs_pkg::mem_req_t               req_i,
  output logic [acs_pkg::DataW-1:0]       rdata_o
);
  import acs_pkg::*;

  logic [DataW-1:0]    mem_q [MemDepth];
  logic [MemDepth-1:0] vld_q;
  logic [DataW-1:0]    rdata_q;
  logic                rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.raddr];
      end
    end
  end

  // never-written words read as zero
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

### hw/rtl/acs_alu.sv
// accumulator update for one decoded instruction
// uses acs_pkg for the opcode type and data width
module acs_alu (
  input  acs_pkg::op_e                op_i,
  input  logic [acs_pkg::DataW-1:0]   acc_i,
  input  logic [acs_pkg::DataW-1:0]   operand_i,
  output logic [acs_pkg::DataW-1:0]   acc_o
);
  import acs_pkg::*;

  always_comb begin
    unique case (op_i)
      OP_LOAD:  acc_o = operand_i;
      OP_ADD:   acc_o = acc_i + operand_i;
      OP_SUB:   acc_o = acc_i - operand_i;
      OP_AND:   acc_o = acc_i & operand_i;
      OP_OR:    acc_o = acc_i | operand_i;
      OP_NOT:   acc_o = ~acc_i;
      OP_STORE: acc_o = acc_i;
      OP_JUMP:  acc_o = acc_i;
      default:  acc_o = acc_i;
    endcase
  end

endmodule

### hw/rtl/accumulator_cpu_step.sv
// top level of the 8-bit accumulator machine step block
// depends on acs_pkg, acs_mem and acs_alu
//
// usage:
//   input channel (in_valid_i / in_ready_o) carries one command item:
//   write a memory word, read a memory word, run one instruction, or a
//   no-op code that just reports the current state.
//   output channel (out_valid_o / out_ready_i) returns one result item per
//   command: pc, accumulator and instruction register after the command,
//   plus the read word for a read command (zero otherwise).
// command flow:
//   write, read and no-op items pass through stage b and then the result
//   register, and can be accepted every cycle unless the output stalls.
//   an execute item does a fetch read, an operand read, then the
//   accumulator update and store write on the single memory; input is
//   held off until it completes.
// reset:
//   pc, accumulator and instruction register clear to zero; memory words
//   read as zero until written (per-word valid bits, no clearing pass).
// stalls:
//   one result register sits on the output; while it is full and not taken
//   the stage behind it holds; input ready drops once that stage is full.
module accumulator_cpu_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic [4:0]        address_i,
  input  logic signed [7:0] write_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [4:0]        pc_out_o,
  output logic signed [7:0] acc_out_o,
  output logic [7:0]        instr_out_o,
  output logic signed [7:0] read_data_o
);
  import acs_pkg::*;

  // handshake and stage control
  logic in_fire;
  logic out_free;
  logic b_exec;
  logic b_done;
  logic c_done;
  cmd_e in_cmd;

  // stage b: memory read data for the item it holds
  logic b_valid_q;
  cmd_e b_cmd_q;
  // stage c: operand read data for an execute
  logic c_valid_q;

  // architectural state
  logic [AddrW-1:0] pc_q;
  logic [DataW-1:0] acc_q;
  logic [DataW-1:0] instr_q;

  // result register
  logic             out_valid_q;
  logic [AddrW-1:0] pc_out_q;
  logic [DataW-1:0] acc_out_q;
  logic [DataW-1:0] instr_out_q;
  logic [DataW-1:0] rd_out_q;

  mem_req_t         mem_req;
  logic [DataW-1:0] mem_rdata;
  op_e              c_op;
  op_e              b_op;
  logic [DataW-1:0] alu_acc;

  assign in_cmd   = cmd_e'(command_i);
  assign out_free = !out_valid_q || out_ready_i;

  // an execute in stage b never waits: it only updates pc/instr and
  // issues the operand read; the output wait happens in stage c
  assign b_exec = b_valid_q && (b_cmd_q == CMD_EXEC);
  assign b_done = b_valid_q && !b_exec && out_free;
  assign c_done = c_valid_q && out_free;

  // interlock: nothing enters while an execute is in flight, so fetch,
  // operand read and store never touch the memory in the same cycle
  assign in_ready_o = !c_valid_q && !b_exec && (!b_valid_q || b_done);
  assign in_fire    = in_valid_i && in_ready_o;

  assign b_op = op_e'(mem_rdata[DataW-1 -: OpW]);
  assign c_op = op_e'(instr_q[DataW-1 -: OpW]);

  // memory port: write command at accept, store at the end of execute;
  // reads are fetch or read-command at accept, operand in stage b
  always_comb begin
    mem_req.we    = (in_fire && (in_cmd == CMD_WRITE)) || (c_done && (c_op == OP_STORE));
    mem_req.waddr = c_valid_q ? instr_q[AddrW-1:0] : address_i;
    mem_req.wdata = c_valid_q ? acc_q : $unsigned(write_data_i);
    mem_req.re    = (in_fire && ((in_cmd == CMD_EXEC) || (in_cmd == CMD_READ))) || b_exec;
    priority if (b_exec) begin
      mem_req.raddr = mem_rdata[AddrW-1:0];
    end else if (in_cmd == CMD_EXEC) begin
      mem_req.raddr = pc_q;
    end else begin
      mem_req.raddr = address_i;
    end
  end

  acs_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  acs_alu u_alu (
    .op_i      (c_op),
    .acc_i     (acc_q),
    .operand_i (mem_rdata),
    .acc_o     (alu_acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      b_cmd_q     <= CMD_NOP;
      c_valid_q   <= 1'b0;
      pc_q        <= '0;
      acc_q       <= '0;
      instr_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        b_valid_q <= 1'b1;
        b_cmd_q   <= in_cmd;
      end else if (b_done || b_exec) begin
        b_valid_q <= 1'b0;
      end

      if (b_exec) begin
        c_valid_q <= 1'b1;
      end else if (c_done) begin
        c_valid_q <= 1'b0;
      end

      // fetch: latch instruction, advance or jump (pc wraps at memory end)
      if (b_exec) begin
        instr_q <= mem_rdata;
        pc_q    <= (b_op == OP_JUMP) ? mem_rdata[AddrW-1:0] : pc_q + AddrW'(1);
      end

      if (c_done) begin
        acc_q <= alu_acc;
      end

      if (b_done || c_done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (c_done) begin
      pc_out_q    <= pc_q;
      acc_out_q   <= alu_acc;
      instr_out_q <= instr_q;
      rd_out_q    <= '0;
    end else if (b_done) begin
      pc_out_q    <= pc_q;
      acc_out_q   <= acc_q;
      instr_out_q <= instr_q;
      rd_out_q    <= (b_cmd_q == CMD_READ) ? mem_rdata : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pc_out_o    = pc_out_q;
  assign acc_out_o   = $signed(acc_out_q);
  assign instr_out_o = instr_out_q;
  assign read_data_o = $signed(rd_out_q);

  // an execute fetch always moves on to the operand stage
  a_fetch_to_oper : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_exec |=> c_valid_q)
    else $error("execute fetch did not reach operand stage");

  // only one item in flight while an execute finishes
  a_exec_alone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(c_valid_q && b_valid_q))
    else $error("item overlaps an execute in progress");

  // pc moves only at an instruction fetch
  a_pc_only_on_fetch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !b_exec |=> $stable(pc_q))
    else $error("pc changed outside a fetch");

  // a result never lands in a full, untaken output register
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(b_done || c_done))
    else $error("result register overwritten while stalled");

endmodule

### dv/tb_accumulator_cpu_step.sv
`timescale 1ns / 1ps
// self-checking testbench for accumulator_cpu_step: directed and random command items
// needs acs_pkg and the accumulator_cpu_step rtl; the machine is predicted in-line

module tb_accumulator_cpu_step;
  import acs_pkg::*;

  localparam int unsigned ClkHalf     = 4;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomItems = 600;

  // one result item as the block reports it
  typedef struct packed {
    logic [AddrW-1:0] pc;
    logic [DataW-1:0] acc;
    logic [DataW-1:0] instr;
    logic [DataW-1:0] rdata;
  } step_result_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_EVERY4,
    RX_SPARSE
  } rx_pattern_e;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              command_i    = CMD_NOP;
  logic [AddrW-1:0]        address_i    = '0;
  logic signed [DataW-1:0] write_data_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic [AddrW-1:0]        pc_out_o;
  logic signed [DataW-1:0] acc_out_o;
  logic [DataW-1:0]        instr_out_o;
  logic signed [DataW-1:0] read_data_o;

  accumulator_cpu_step dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pc_out_o     (pc_out_o),
    .acc_out_o    (acc_out_o),
    .instr_out_o  (instr_out_o),
    .read_data_o  (read_data_o)
  );

  // 8 ns clock
  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // machine image kept by the testbench: memory, pc, accumulator, instruction register
  logic [DataW-1:0] mem_img [MemDepth] = '{default: '0};
  logic [AddrW-1:0] pc_m  = '0;
  logic [DataW-1:0] acc_m = '0;
  logic [DataW-1:0] ir_m  = '0;

  // results still owed by the block, oldest first
  step_result_t expected_q [$];

  int unsigned fail_count    = 0;
  int unsigned checked_count = 0;
  int unsigned cycle_count   = 0;
  int unsigned cmd_count [4] = '{default: 0};
  int unsigned op_count  [8] = '{default: 0};

  // sender burst control
  int unsigned burst_left = 4;
  bit          no_gaps    = 1'b0;

  // receiver control; the long hold-off is asked for by bumping holds_asked
  int unsigned holds_asked = 0;
  int unsigned holds_done  = 0;
  int unsigned hold_left   = 0;
  int unsigned rx_phase    = 0;
  rx_pattern_e rx_mode     = RX_ALWAYS;

  function automatic logic [DataW-1:0] encode_instr(op_e op, logic [AddrW-1:0] addr);
    return {op, addr};
  endfunction

  // advance the machine image by one command and return the result it reports
  function automatic step_result_t step_machine(cmd_e cmd, logic [AddrW-1:0] addr,
                                                logic [DataW-1:0] wdata);
    step_result_t     res;
    logic [AddrW-1:0] opnd_addr;
    logic [DataW-1:0] operand;
    op_e              op;
    res.rdata = '0;
    case (cmd)
      CMD_WRITE: mem_img[addr] = wdata;
      CMD_READ:  res.rdata = mem_img[addr];
      CMD_EXEC: begin
        // fetch, then advance pc; the 5-bit counter wraps past the last word
        ir_m      = mem_img[pc_m];
        pc_m      = pc_m + AddrW'(1);
        op        = op_e'(ir_m[DataW-1 -: OpW]);
        opnd_addr = ir_m[AddrW-1:0];
        operand   = mem_img[opnd_addr];
        op_count[op]++;
        case (op)
          OP_LOAD:  acc_m = operand;
          OP_STORE: mem_img[opnd_addr] = acc_m;
          OP_ADD:   acc_m = acc_m + operand;
          OP_SUB:   acc_m = acc_m - operand;
          OP_AND:   acc_m = acc_m & operand;
          OP_OR:    acc_m = acc_m | operand;
          OP_NOT:   acc_m = ~acc_m;
          OP_JUMP:  pc_m = opnd_addr;
        endcase
      end
      default: ;  // unused code reports state only
    endcase
    res.pc    = pc_m;
    res.acc   = acc_m;
    res.instr = ir_m;
    return res;
  endfunction

  // offer one item, hold it until taken, then record what it should produce;
  // outside the pressure test the sender drops valid for a random gap between bursts
  task automatic send_item(cmd_e cmd, logic [AddrW-1:0] addr, logic [DataW-1:0] wdata);
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    address_i    <= addr;
    write_data_i <= wdata;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(step_machine(cmd, addr, wdata));
    cmd_count[cmd]++;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        // idle gap with junk on the payload
        in_valid_i   <= 1'b0;
        command_i    <= 2'($urandom);
        address_i    <= AddrW'($urandom);
        write_data_i <= DataW'($urandom);
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(0, 8);
      end else begin
        burst_left--;
      end
    end
  endtask

  // reset values, the no-op code, every opcode, add and sub wrap, store over the
  // word just fetched, jump to the last word and pc wrap back to zero
  task automatic test_directed();
    send_item(CMD_READ, 5'd31, 8'h00);   // never written, reads zero
    send_item(CMD_NOP, 5'd17, 8'h5A);
    send_item(CMD_WRITE, 5'd0, encode_instr(OP_LOAD, 5'd20));
    send_item(CMD_WRITE, 5'd1, encode_instr(OP_ADD, 5'd21));
    send_item(CMD_WRITE, 5'd2, encode_instr(OP_SUB, 5'd22));
    send_item(CMD_WRITE, 5'd3, encode_instr(OP_AND, 5'd23));
    send_item(CMD_WRITE, 5'd4, encode_instr(OP_OR, 5'd24));
    send_item(CMD_WRITE, 5'd5, encode_instr(OP_NOT, 5'd0));
    send_item(CMD_WRITE, 5'd6, encode_instr(OP_STORE, 5'd6));
    send_item(CMD_WRITE, 5'd7, encode_instr(OP_JUMP, 5'd31));
    send_item(CMD_WRITE, 5'd20, 8'h7F);  // largest positive
    send_item(CMD_WRITE, 5'd21, 8'h01);  // 127 + 1 wraps to -128
    send_item(CMD_WRITE, 5'd22, 8'h01);  // -128 - 1 wraps to 127
    send_item(CMD_WRITE, 5'd23, 8'hFF);
    send_item(CMD_WRITE, 5'd24, 8'h80);  // most negative
    // straight run through the program, word 31 holds zero (load from word 0)
    repeat (10) send_item(CMD_EXEC, AddrW'($urandom), DataW'($urandom));
    send_item(CMD_READ, 5'd6, 8'hC3);    // word overwritten by its own store
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  // back-to-back items, so the block fills and drops its input ready
  task automatic test_backpressure();
    no_gaps = 1'b1;
    holds_asked++;
    repeat (24) begin
      send_item(cmd_e'($urandom_range(0, 3)), AddrW'($urandom), DataW'($urandom));
    end
    no_gaps = 1'b0;
  endtask

  // mostly small programs: a run of writes (instructions or data bytes),
  // a run of executes, a few reads; the rest is random commands as noise
  task automatic test_random_programs(int unsigned n_items);
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(cmd_e'($urandom_range(0, 3)), AddrW'($urandom), DataW'($urandom));
          sent++;
        end
      end else begin
        repeat ($urandom_range(2, 10)) begin
          if ($urandom_range(0, 1) == 0) begin
            send_item(CMD_WRITE, AddrW'($urandom),
                      encode_instr(op_e'($urandom_range(0, 7)), AddrW'($urandom)));
          end else begin
            send_item(CMD_WRITE, AddrW'($urandom), DataW'($urandom));
          end
          sent++;
        end
        repeat ($urandom_range(3, 16)) begin
          send_item(CMD_EXEC, AddrW'($urandom), DataW'($urandom));
          sent++;
        end
        repeat ($urandom_range(0, 3)) begin
          send_item(CMD_READ, AddrW'($urandom), DataW'($urandom));
          sent++;
        end
      end
    end
  endtask

  // receiver: long hold-off on request, otherwise a random stall pattern that is
  // redrawn when its phase count runs out, including stretches that never stall
  always @(posedge clk_i) begin
    if (hold_left == 0 && holds_done != holds_asked) begin
      hold_left   <= HoldCycles;
      holds_done  <= holds_done + 1;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      if (rx_phase == 0) begin
        rx_mode  <= rx_pattern_e'($urandom_range(0, 3));
        rx_phase <= $urandom_range(16, 96);
      end else begin
        rx_phase <= rx_phase - 1;
      end
      case (rx_mode)
        RX_ALWAYS: out_ready_i <= 1'b1;
        RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        RX_EVERY4: out_ready_i <= (rx_phase[1:0] == 2'd0);
        RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // compare each taken result with the oldest expectation, field by field
  always @(posedge clk_i) begin : check_results
    step_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result item: pc_out %0d acc_out %0d instr_out 0x%02h",
               pc_out_o, acc_out_o, instr_out_o);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        checked_count++;
        if (pc_out_o !== want.pc) begin
          $error("pc_out: expected %0d, actual %0d", want.pc, pc_out_o);
          fail_count++;
        end
        if (acc_out_o !== want.acc) begin
          $error("acc_out: expected %0d, actual %0d", $signed(want.acc), acc_out_o);
          fail_count++;
        end
        if (instr_out_o !== want.instr) begin
          $error("instr_out: expected 0x%02h, actual 0x%02h", want.instr, instr_out_o);
          fail_count++;
        end
        if (read_data_o !== want.rdata) begin
          $error("read_data: expected %0d, actual %0d", $signed(want.rdata), read_data_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $error("timeout after %0d cycles, %0d results outstanding",
             cycle_count, expected_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random_programs(RandomItems);

    // let the block drain, then a few quiet cycles for anything stray
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d writes, %0d executes, %0d reads, %0d no-ops; %0d results checked",
             cmd_count[CMD_WRITE], cmd_count[CMD_EXEC], cmd_count[CMD_READ],
             cmd_count[CMD_NOP], checked_count);
    $display("opcodes run: ld %0d st %0d add %0d sub %0d and %0d or %0d not %0d jmp %0d",
             op_count[OP_LOAD], op_count[OP_STORE], op_count[OP_ADD], op_count[OP_SUB],
             op_count[OP_AND], op_count[OP_OR], op_count[OP_NOT], op_count[OP_JUMP]);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/acs_pkg.sv
hw/rtl/acs_mem.sv
hw/rtl/acs_alu.sv
hw/rtl/accumulator_cpu_step.sv
dv/tb_accumulator_cpu_step.sv
